FILE: design/fpm_pkg.sv
package fpm_pkg;

	localparam int MS_PER_SEC_W = 10;
	localparam logic [MS_PER_SEC_W-1:0] MS_PER_SEC = 10'd1000;
	localparam int DIV_CNT_W = $clog2(MS_PER_SEC_W);

	localparam int TIME_W = 32;
	localparam int FPS_W = 22;
	localparam int RATE_W = 10;
	localparam int SPS_W = 7;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_SEC = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_RATE = 2'd2;

	localparam logic OP_START = 1'b0;
	localparam logic OP_FRAME = 1'b1;

	localparam int OUT_DATA_W = 88;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ACC,
		ST_RENDER,
		ST_RING,
		ST_PUSH,
		ST_DONE
	} fpm_state_t;

	typedef struct packed {
		logic in_ready;
		logic div_go;
		logic ring_re;
		logic ring_we;
		logic out_load;
	} fpm_ctl_t;

endpackage

FILE: design/fpm_div.sv
module fpm_div
	import fpm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [MS_PER_SEC_W-1:0] divisor,
	output logic                    done,
	output logic [MS_PER_SEC_W-1:0] quotient
);

	// restoring divide of the constant by divisor, one bit per cycle
	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CNT_W-1:0]    cnt_q;
	logic [MS_PER_SEC_W-1:0] rem_q;
	logic [MS_PER_SEC_W-1:0] quo_q;
	logic [MS_PER_SEC_W-1:0] dvs_q;
	logic [MS_PER_SEC_W:0]   trial;
	logic                    fits;

	assign trial = {rem_q, quo_q[MS_PER_SEC_W-1]};
	assign fits = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(MS_PER_SEC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= MS_PER_SEC;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= MS_PER_SEC_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[MS_PER_SEC_W-1:0];
			end
			quo_q <= {quo_q[MS_PER_SEC_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

FILE: design/frame_pacer_fps_meter_unit.sv
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser opcode, tdata now_ms
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata render_ok, fps, ticks, delta
// cfg       in   cfg_valid/cfg_ready            cfg_index, cfg_data
//
// Frame beat: accumulate, render; if it closes a sample, ring read, sum update and write.
// Start beat: the bit-serial divides of 1000 give interval and split.
// One beat in flight; a finished result waits in the output register while the next
// beat is taken. The block stalls in its last step only while that register is full.
// Reset is asynchronous; the sample ring memory needs no clearing pass.
module frame_pacer_fps_meter_unit
	import fpm_pkg::*;
#(
	parameter int WINDOW_DEPTH = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [TIME_W-1:0]     s_axis_tdata,  // now_ms
	input  logic                  s_axis_tuser,  // opcode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // render_ok, average_fps, global_ticks,
	                                             // delta_ticks, zero pad
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam int OLD_W = FILL_W + 1;
	localparam int CMP_W = (FILL_W > SPS_W) ? FILL_W : SPS_W;
	localparam int SUM_RAW_W = COUNT_BITS + FILL_W;
	localparam int SUM_W = (SUM_RAW_W > FPS_W) ? SUM_RAW_W : FPS_W + 1;

	fpm_state_t state_q, state_d;
	fpm_ctl_t   ctl;

	logic [RATE_W-1:0] rate_q;
	logic [SPS_W-1:0]  sps_q;
	logic              unlock_q;

	logic                  op_q;
	logic [TIME_W-1:0]     now_q;
	logic [TIME_W-1:0]     cur_time_q;
	logic [TIME_W-1:0]     loop_delta_q;
	logic [TIME_W-1:0]     elapsed_q;
	logic [TIME_W-1:0]     sample_start_q;
	logic [TIME_W-1:0]     diff_q;
	logic [COUNT_BITS-1:0] frame_cnt_q;
	logic [RATE_W-1:0]     interval_q;
	logic [RATE_W-1:0]     split_q;
	logic [FILL_W-1:0]     fill_q;
	logic [IDX_W-1:0]      head_q;
	logic [SUM_W-1:0]      fps_sum_q;
	logic [SUM_W-1:0]      fps_out_q;
	logic                  render_q;
	logic                  close_q;
	logic                  full_q;

	logic [COUNT_BITS-1:0] ring_mem [WINDOW_DEPTH];
	logic [COUNT_BITS-1:0] ring_rdata_q;

	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	logic                div_int_done;
	logic                div_spl_done;
	logic [RATE_W-1:0]   div_int_q;
	logic [RATE_W-1:0]   div_spl_q;
	logic [RATE_W-1:0]   rate_eff;
	logic [SPS_W-1:0]    sps_eff;

	logic [TIME_W-1:0] delta;
	logic [TIME_W:0]   acc_sum;
	logic              ge;
	logic              grant;
	logic              close;
	logic              full;
	logic [CMP_W-1:0]  fill_x;
	logic [CMP_W-1:0]  sps_x;
	logic [OLD_W-1:0]  head_x;
	logic [OLD_W-1:0]  fill_ext;
	logic [OLD_W-1:0]  oldest_x;
	logic [IDX_W-1:0]  oldest;
	logic [SUM_W-1:0]  sum_push;
	logic [FPS_W-1:0]  fps_sat;
	logic              accept;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_W'(60);
			sps_q <= SPS_W'(4);
			unlock_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TARGET_RATE:     rate_q <= cfg_data;
				CFG_SAMPLES_PER_SEC: sps_q <= cfg_data[SPS_W-1:0];
				CFG_UNLOCK_RATE:     unlock_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign rate_eff = (rate_q == '0) ? RATE_W'(1) : rate_q;
	assign sps_eff = (sps_q == '0) ? SPS_W'(1) : sps_q;

	fpm_div u_div_interval (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_go),
		.divisor  (rate_eff),
		.done     (div_int_done),
		.quotient (div_int_q)
	);

	fpm_div u_div_split (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_go),
		.divisor  (RATE_W'(sps_eff)),
		.done     (div_spl_done),
		.quotient (div_spl_q)
	);

	assign accept = s_axis_tvalid && ctl.in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (s_axis_tuser == OP_START) ? ST_DIV : ST_ACC;
				end
			end
			ST_DIV: begin
				if (div_int_done && div_spl_done) begin
					state_d = ST_DONE;
				end
			end
			ST_ACC:    state_d = ST_RENDER;
			ST_RENDER: state_d = close ? ST_RING : ST_DONE;
			ST_RING:   state_d = ST_PUSH;
			ST_PUSH:   state_d = ST_DONE;
			ST_DONE: begin
				if (ctl.out_load) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_IDLE:   begin
				ctl.in_ready = 1'b1;
				ctl.div_go = s_axis_tvalid && (s_axis_tuser == OP_START);
			end
			ST_RENDER: ctl.ring_re = close;
			ST_PUSH:   ctl.ring_we = 1'b1;
			ST_DONE:   ctl.out_load = !m_valid_q || m_axis_tready;
			default:   ;
		endcase
	end

	assign s_axis_tready = ctl.in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign delta = now_q - cur_time_q;
	assign acc_sum = {1'b0, elapsed_q} + {1'b0, delta};
	assign ge = elapsed_q >= TIME_W'(interval_q);
	assign grant = ge || unlock_q;
	assign close = diff_q > TIME_W'(split_q);

	assign fill_x = CMP_W'(fill_q);
	assign sps_x = CMP_W'(sps_eff);
	assign full = (fill_q == FILL_W'(WINDOW_DEPTH)) || (fill_x >= sps_x);

	assign head_x = OLD_W'(head_q);
	assign fill_ext = OLD_W'(fill_q);
	assign oldest_x = (head_x >= fill_ext) ? head_x - fill_ext
		: head_x + OLD_W'(WINDOW_DEPTH) - fill_ext;
	assign oldest = oldest_x[IDX_W-1:0];

	assign sum_push = fps_sum_q + SUM_W'(frame_cnt_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= s_axis_tuser;
			now_q <= s_axis_tdata;
		end
		if (state_q == ST_ACC) begin
			diff_q <= now_q - sample_start_q;
		end
		if (state_q == ST_RENDER) begin
			close_q <= close;
			full_q <= full;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ring_we) begin
			ring_mem[head_q] <= frame_cnt_q;
		end
		if (ctl.ring_re) begin
			ring_rdata_q <= ring_mem[oldest];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_time_q <= '0;
			loop_delta_q <= '0;
			elapsed_q <= '0;
			sample_start_q <= '0;
			frame_cnt_q <= '0;
			interval_q <= '0;
			split_q <= '0;
			fill_q <= '0;
			head_q <= '0;
			fps_sum_q <= '0;
			fps_out_q <= '0;
			render_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						render_q <= 1'b0;
					end
				end
				ST_DIV: begin
					if (div_int_done && div_spl_done) begin
						cur_time_q <= now_q;
						sample_start_q <= now_q;
						elapsed_q <= '0;
						loop_delta_q <= '0;
						fps_out_q <= '0;
						interval_q <= div_int_q;
						split_q <= div_spl_q;
					end
				end
				ST_ACC: begin
					loop_delta_q <= delta;
					cur_time_q <= now_q;
					elapsed_q <= acc_sum[TIME_W] ? '1 : acc_sum[TIME_W-1:0];
				end
				ST_RENDER: begin
					if (grant) begin
						render_q <= 1'b1;
						if (frame_cnt_q != '1) begin
							frame_cnt_q <= frame_cnt_q + 1'b1;
						end
						elapsed_q <= ge ? elapsed_q - TIME_W'(interval_q) : '0;
					end
					if (close) begin
						sample_start_q <= sample_start_q + TIME_W'(split_q);
					end
				end
				ST_RING: begin
					if (full_q) begin
						fps_sum_q <= fps_sum_q - SUM_W'(ring_rdata_q);
					end else begin
						fill_q <= fill_q + 1'b1;
					end
				end
				ST_PUSH: begin
					fps_sum_q <= sum_push;
					fps_out_q <= sum_push;
					frame_cnt_q <= '0;
					head_q <= (head_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
				end
				ST_DONE: ;
				default: ;
			endcase
		end
	end

	assign fps_sat = (|fps_out_q[SUM_W-1:FPS_W]) ? '1 : fps_out_q[FPS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			m_data_q <= {1'b0, loop_delta_q, cur_time_q, fps_sat, render_q && (op_q == OP_FRAME)
				&& !close_q | (render_q && (op_q == OP_FRAME))};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;

endmodule
